/* src/gbn_pkg.sv */
// Package for the go-back-N sender window: request, status and timer codes,
// plus the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package gbn_pkg;

   // Fixed field widths
   localparam int WIN_W  = 3;
   localparam int ACK_W  = 3;
   localparam int TYPE_W = 2;
   localparam int STAT_W = 3;
   localparam int TMR_W  = 2;
   localparam int DUP_W  = 2;

   localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

   // Request types
   localparam logic [TYPE_W-1:0] REQ_SEND    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ACK     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_REFUSED = 3'd0;
   localparam logic [STAT_W-1:0] ST_SENT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_ADVANCE = 3'd2;
   localparam logic [STAT_W-1:0] ST_DUPACK  = 3'd3;
   localparam logic [STAT_W-1:0] ST_CORRUPT = 3'd4;
   localparam logic [STAT_W-1:0] ST_RESEND  = 3'd5;

   // Timer commands
   localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
   localparam logic [TMR_W-1:0] TMR_START = 2'd1;
   localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

   // Duplicate counter: wraps modulo 3, fast retransmit on reaching 2
   localparam logic [DUP_W-1:0] DUP_TRIGGER = 2'd2;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_SEND,
      OP_REFUSE,
      OP_CORRUPT,
      OP_ADVANCE,
      OP_DUP,
      OP_TO_EMPTY,
      OP_RESEND_START,
      OP_RESEND_NEXT,
      OP_FETCH_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Decisions the datapath reports back about the latched item
   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic              refused;
      logic              ack_ok;
      logic              in_window;
      logic              dup_hit;
      logic              none_out;
      logic              more;
   } dp_stat_type;

endpackage

/* src/go_back_n_sender_window_core.sv */
// Go-back-N sender window with cumulative acks and duplicate-ack fast
// retransmit. A send stores its payload at the next sequence number and
// transmits it unless the window (window_size, capped at SEQ_SIZE - 1) is
// full. A corrupt ack is dropped; an in-window ack moves the base; any other
// good ack bumps a modulo-3 counter and resends the base packet when it hits
// 2. A timeout resends every outstanding packet, one item per packet, the
// last flagged by rsp_last. One item is handled at a time: no new item is
// taken until the result of the last one has been taken, and each resent
// packet costs one read of the registered payload store before its result.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp and gbn_ram.
`timescale 1ns / 1ps

module go_back_n_sender_window_core
   import gbn_pkg::*;
#(
   parameter int SEQ_SIZE     = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_we,
   input  logic [WIN_W-1:0]                            csr_wdata,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [TYPE_W-1:0]                           req_type,
   input  logic [PAYLOAD_BITS-1:0]                     req_payload,
   input  logic [ACK_W-1:0]                            req_ack_num,
   input  logic                                        req_ack_ok,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [STAT_W-1:0]                           rsp_status,
   output logic                                        rsp_tx_valid,
   output logic [(SEQ_SIZE > 1 ? $clog2(SEQ_SIZE) : 1)-1:0] rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0]                     rsp_tx_payload,
   output logic [TMR_W-1:0]                            rsp_timer_cmd,
   output logic                                        rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencing
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Window state, store and result register
   gbn_dp #(
      .SEQ_SIZE     (SEQ_SIZE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_payload    (req_payload),
      .req_ack_num    (req_ack_num),
      .req_ack_ok     (req_ack_ok),
      .rsp_status     (rsp_status),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_seq     (rsp_tx_seq),
      .rsp_tx_payload (rsp_tx_payload),
      .rsp_timer_cmd  (rsp_timer_cmd),
      .rsp_last       (rsp_last)
   );

endmodule

/* src/gbn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gbn_dp.sv */
// Datapath of the go-back-N sender: window state, latched item, payload
// store with valid bits, and the result register.
// Depends on gbn_pkg and gbn_ram.
`timescale 1ns / 1ps

module gbn_dp
   import gbn_pkg::*;
#(
   parameter int SEQ_SIZE     = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  dp_cmd_type                                  cmd,
   output dp_stat_type                                 stat,
   input  logic                                        csr_we,
   input  logic [WIN_W-1:0]                            csr_wdata,
   input  logic [TYPE_W-1:0]                           req_type,
   input  logic [PAYLOAD_BITS-1:0]                     req_payload,
   input  logic [ACK_W-1:0]                            req_ack_num,
   input  logic                                        req_ack_ok,
   output logic [STAT_W-1:0]                           rsp_status,
   output logic                                        rsp_tx_valid,
   output logic [(SEQ_SIZE > 1 ? $clog2(SEQ_SIZE) : 1)-1:0] rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0]                     rsp_tx_payload,
   output logic [TMR_W-1:0]                            rsp_timer_cmd,
   output logic                                        rsp_last
);

   localparam int SEQ_W = (SEQ_SIZE > 1) ? $clog2(SEQ_SIZE) : 1;
   localparam int CW    = ((SEQ_W > WIN_W) ? SEQ_W : WIN_W) + 1;
   localparam int AM_W  = ((SEQ_W > ACK_W) ? SEQ_W : ACK_W) + 1;
   localparam logic [SEQ_W:0] SEQ_EXT  = (SEQ_W + 1)'(SEQ_SIZE);
   localparam logic [CW-1:0]  SEQ_TOP  = CW'(SEQ_SIZE - 1);
   localparam logic [AM_W-1:0] SEQ_AM  = AM_W'(SEQ_SIZE);

   // (a + b) mod SEQ_SIZE, both below SEQ_SIZE
   function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
      logic [SEQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SEQ_EXT) begin
         s = s - SEQ_EXT;
      end
      return s[SEQ_W-1:0];
   endfunction

   // (a - b) mod SEQ_SIZE, both below SEQ_SIZE
   function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
      logic [SEQ_W:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + SEQ_EXT - {1'b0, b};
      end
      return s[SEQ_W-1:0];
   endfunction

   // Window state
   logic [SEQ_W-1:0]    base_ff, base_in;
   logic [SEQ_W-1:0]    next_ff, next_in;
   logic [DUP_W-1:0]    dup_ff, dup_in;
   logic [WIN_W-1:0]    win_ff;
   logic [SEQ_SIZE-1:0] vld_ff, vld_in;

   // Latched item
   logic [TYPE_W-1:0]       type_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [ACK_W-1:0]        ack_ff;
   logic                    ok_ff;

   // Resend walk and store read
   logic [SEQ_W-1:0] ridx_ff, ridx_in;
   logic [SEQ_W-1:0] rd_seq_ff;
   logic             rd_vld_ff;
   logic [SEQ_W-1:0] rd_addr;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;
   logic             ram_we;

   // Result register
   logic [STAT_W-1:0]       status_ff;
   logic                    txv_ff;
   logic [SEQ_W-1:0]        txs_ff;
   logic [PAYLOAD_BITS-1:0] txp_ff;
   logic [TMR_W-1:0]        tmr_ff;
   logic                    last_ff;

   // Derived values
   logic [AM_W-1:0]  ack_red;
   logic [SEQ_W-1:0] ack_seq;
   logic [SEQ_W-1:0] inflight;
   logic [SEQ_W-1:0] ack_diff;
   logic [CW-1:0]    eff_win;
   logic [SEQ_W-1:0] ack_base;
   logic [SEQ_W-1:0] ridx_nx;
   logic [SEQ_W:0]   ridx_nx_end;

   // Reduce the ack number modulo the sequence space (at most three steps)
   always_comb begin
      ack_red = AM_W'(ack_ff);
      for (int k = 0; k < 4; k++) begin
         if (ack_red >= SEQ_AM) begin
            ack_red = ack_red - SEQ_AM;
         end
      end
      ack_seq = ack_red[SEQ_W-1:0];
   end

   // Window tests
   always_comb begin
      inflight = seq_sub(next_ff, base_ff);
      ack_diff = seq_sub(ack_seq, base_ff);
      ack_base = (ack_seq == SEQ_TOP[SEQ_W-1:0]) ? '0 : ack_seq + 1'b1;
      eff_win  = (CW'(win_ff) > SEQ_TOP) ? SEQ_TOP : CW'(win_ff);
      ridx_nx  = ridx_ff + 1'b1;
      ridx_nx_end = {1'b0, ridx_nx} + 1'b1;
   end

   always_comb begin
      stat.kind      = type_ff;
      stat.refused   = CW'(inflight) >= eff_win;
      stat.ack_ok    = ok_ff;
      stat.in_window = CW'(ack_diff) < CW'(win_ff);
      stat.dup_hit   = (dup_ff == (DUP_TRIGGER - 1'b1));
      stat.none_out  = (inflight == '0);
      stat.more      = (type_ff == REQ_TIMEOUT) && !last_ff;
   end

   // Store read address: base for a fast retransmit or the first resend
   always_comb begin
      if (cmd.op == OP_RESEND_NEXT) begin
         rd_addr = seq_add(base_ff, ridx_nx);
      end else begin
         rd_addr = base_ff;
      end
   end

   assign ram_we = (cmd.op == OP_SEND);

   gbn_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_ff),
      .wr_data (pay_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next window state
   always_comb begin
      base_in = base_ff;
      next_in = next_ff;
      dup_in  = dup_ff;
      vld_in  = vld_ff;
      ridx_in = ridx_ff;
      case (cmd.op)
         OP_SEND: begin
            vld_in[next_ff] = 1'b1;
            next_in = (next_ff == SEQ_TOP[SEQ_W-1:0]) ? '0 : next_ff + 1'b1;
         end
         OP_ADVANCE: begin
            base_in = ack_base;
            dup_in  = '0;
         end
         OP_DUP: begin
            dup_in = (dup_ff == DUP_TRIGGER) ? '0 : dup_ff + 1'b1;
         end
         OP_RESEND_START: ridx_in = '0;
         OP_RESEND_NEXT:  ridx_in = ridx_nx;
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         next_ff <= '0;
         dup_ff  <= '0;
         win_ff  <= WIN_RESET;
         vld_ff  <= '0;
         last_ff <= 1'b1;
      end else begin
         base_ff <= base_in;
         next_ff <= next_in;
         dup_ff  <= dup_in;
         vld_ff  <= vld_in;
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         case (cmd.op)
            OP_SEND, OP_REFUSE, OP_CORRUPT, OP_ADVANCE, OP_DUP, OP_TO_EMPTY:
               last_ff <= 1'b1;
            OP_RESEND_START:
               last_ff <= (inflight == SEQ_W'(1));
            OP_RESEND_NEXT:
               last_ff <= (ridx_nx_end == {1'b0, inflight});
            default: ;
         endcase
      end
   end

   // Latched item, resend index and read tracking
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         type_ff <= req_type;
         pay_ff  <= req_payload;
         ack_ff  <= req_ack_num;
         ok_ff   <= req_ack_ok;
      end
      ridx_ff   <= ridx_in;
      rd_seq_ff <= rd_addr;
      rd_vld_ff <= vld_ff[rd_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SEND: begin
            status_ff <= ST_SENT;
            txv_ff    <= 1'b1;
            txs_ff    <= next_ff;
            txp_ff    <= pay_ff;
            tmr_ff    <= (base_ff == next_ff) ? TMR_START : TMR_NONE;
         end
         OP_REFUSE, OP_CORRUPT: begin
            status_ff <= (cmd.op == OP_REFUSE) ? ST_REFUSED : ST_CORRUPT;
            txv_ff    <= 1'b0;
            txs_ff    <= '0;
            txp_ff    <= '0;
            tmr_ff    <= TMR_NONE;
         end
         OP_ADVANCE: begin
            status_ff <= ST_ADVANCE;
            txv_ff    <= 1'b0;
            txs_ff    <= '0;
            txp_ff    <= '0;
            tmr_ff    <= (ack_base != next_ff) ? TMR_START : TMR_STOP;
         end
         OP_DUP: begin
            status_ff <= ST_DUPACK;
            txv_ff    <= stat.dup_hit;
            txs_ff    <= '0;
            txp_ff    <= '0;
            tmr_ff    <= TMR_NONE;
         end
         OP_TO_EMPTY, OP_RESEND_START: begin
            status_ff <= ST_RESEND;
            txv_ff    <= (cmd.op == OP_RESEND_START);
            txs_ff    <= '0;
            txp_ff    <= '0;
            tmr_ff    <= TMR_START;
         end
         OP_RESEND_NEXT: begin
            tmr_ff <= TMR_NONE;
         end
         OP_FETCH_LOAD: begin
            txs_ff <= rd_seq_ff;
            txp_ff <= rd_vld_ff ? ram_rd_data : '0;
         end
         default: ;
      endcase
   end

   assign rsp_status     = status_ff;
   assign rsp_tx_valid   = txv_ff;
   assign rsp_tx_seq     = txs_ff;
   assign rsp_tx_payload = txp_ff;
   assign rsp_timer_cmd  = tmr_ff;
   assign rsp_last       = last_ff;

endmodule

/* src/gbn_ctrl.sv */
// Controller of the go-back-N sender: sequences accept, evaluation, store
// reads and result delivery. Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_ctrl
   import gbn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_FETCH,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (stat.kind)
               REQ_SEND: begin
                  cmd.op   = stat.refused ? OP_REFUSE : OP_SEND;
                  state_in = S_RESP;
               end
               REQ_ACK: begin
                  if (!stat.ack_ok) begin
                     cmd.op   = OP_CORRUPT;
                     state_in = S_RESP;
                  end else if (stat.in_window) begin
                     cmd.op   = OP_ADVANCE;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_DUP;
                     state_in = stat.dup_hit ? S_FETCH : S_RESP;
                  end
               end
               REQ_TIMEOUT: begin
                  if (stat.none_out) begin
                     cmd.op   = OP_TO_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_RESEND_START;
                     state_in = S_FETCH;
                  end
               end
               default: state_in = S_IDLE;   // unknown type: no result
            endcase
         end
         S_FETCH: begin
            cmd.op   = OP_FETCH_LOAD;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (stat.more) begin
                  cmd.op   = OP_RESEND_NEXT;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

/* tb/gbn_checker.sv */
// Checker for the go-back-N sender window: watches the csr, req and rsp ports,
// keeps its own copy of the window state and compares every result item.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_checker
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WIN_W-1:0]  csr_wdata,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [31:0]       req_payload,
   input  logic [ACK_W-1:0]  req_ack_num,
   input  logic              req_ack_ok,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic              rsp_tx_valid,
   input  logic [2:0]        rsp_tx_seq,
   input  logic [31:0]       rsp_tx_payload,
   input  logic [TMR_W-1:0]  rsp_timer_cmd,
   input  logic              rsp_last,
   output int                fail_count,
   output int                pending,
   output int                checked
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              tx_valid;
      logic [2:0]        tx_seq;
      logic [31:0]       tx_payload;
      logic [TMR_W-1:0]  timer_cmd;
      logic              fin;
   } tx_result_type;

   tx_result_type    due_results[$];

   // Shadow of the window state
   logic [WIN_W-1:0] win_size;
   logic [2:0]       base_seq;
   logic [2:0]       next_seq;
   logic [DUP_W-1:0] dup_count;
   logic [31:0]      sent_words [8];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   // Queue one expected result; packet fields read as zero without a packet
   function automatic void expect_tx(logic [STAT_W-1:0] st, logic txv, logic [2:0] seq,
                                     logic [TMR_W-1:0] tmr, logic fin);
      tx_result_type r;
      r.status     = st;
      r.tx_valid   = txv;
      r.tx_seq     = txv ? seq : 3'd0;
      r.tx_payload = txv ? sent_words[seq] : 32'd0;
      r.timer_cmd  = tmr;
      r.fin        = fin;
      due_results.push_back(r);
   endfunction

   // Work out the results of one accepted item and update the shadow state
   function automatic void predict_window(logic [TYPE_W-1:0] kind, logic [31:0] word,
                                          logic [ACK_W-1:0] ack, logic ok);
      logic [2:0] in_flight;
      logic [2:0] ack_gap;
      logic [2:0] seq;
      in_flight = next_seq - base_seq;
      ack_gap   = ack - base_seq;
      case (kind)
         REQ_SEND: begin
            // window size is 3 bits, so it never exceeds SEQ_SIZE - 1
            if (in_flight >= win_size) begin
               expect_tx(ST_REFUSED, 1'b0, 3'd0, TMR_NONE, 1'b1);
            end else begin
               sent_words[next_seq] = word;
               expect_tx(ST_SENT, 1'b1, next_seq,
                         (base_seq == next_seq) ? TMR_START : TMR_NONE, 1'b1);
               next_seq = next_seq + 3'd1;
            end
         end
         REQ_ACK: begin
            if (!ok) begin
               expect_tx(ST_CORRUPT, 1'b0, 3'd0, TMR_NONE, 1'b1);
            end else if (ack_gap < win_size) begin
               base_seq  = ack + 3'd1;
               dup_count = '0;
               expect_tx(ST_ADVANCE, 1'b0, 3'd0,
                         (base_seq != next_seq) ? TMR_START : TMR_STOP, 1'b1);
            end else begin
               // counts modulo 3: wraps to zero after the trigger value
               dup_count = (dup_count == DUP_TRIGGER) ? '0 : dup_count + 2'd1;
               expect_tx(ST_DUPACK, dup_count == DUP_TRIGGER, base_seq, TMR_NONE, 1'b1);
            end
         end
         REQ_TIMEOUT: begin
            if (in_flight == 3'd0) begin
               expect_tx(ST_RESEND, 1'b0, 3'd0, TMR_START, 1'b1);
            end else begin
               for (int i = 0; i < in_flight; i++) begin
                  seq = base_seq + 3'(i);
                  expect_tx(ST_RESEND, 1'b1, seq, (i == 0) ? TMR_START : TMR_NONE,
                            i == in_flight - 1);
               end
            end
         end
         default: ;  // unknown request type: ignored, no result
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t gbn_checker: %s expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Sample both channels at the rising edge
   always @(posedge clock) begin : watch
      tx_result_type want;
      if (reset) begin
         due_results.delete();
         win_size  = WIN_RESET;
         base_seq  = '0;
         next_seq  = '0;
         dup_count = '0;
         for (int i = 0; i < 8; i++) sent_words[i] = '0;
      end else begin
         if (csr_we) win_size = csr_wdata;
         if (req_valid && req_ready)
            predict_window(req_type, req_payload, req_ack_num, req_ack_ok);
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t gbn_checker: result with nothing expected, %s %0d seq %0d",
                        $time, "expected none, got status", rsp_status, rsp_tx_seq);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               checked++;
               check_field("status", want.status, rsp_status);
               check_field("tx_valid", want.tx_valid, rsp_tx_valid);
               check_field("tx_seq", want.tx_seq, rsp_tx_seq);
               check_field("tx_payload", want.tx_payload, rsp_tx_payload);
               check_field("timer_cmd", want.timer_cmd, rsp_timer_cmd);
               check_field("last", want.fin, rsp_last);
            end
         end
      end
      pending = due_results.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for go_back_n_sender_window_core: clock, reset, stimulus on
// the req and csr ports, receiver stalls and the verdict.
// Depends on gbn_pkg, gbn_checker and the core.
`timescale 1ns / 1ps

module tb
   import gbn_pkg::*;
();

   localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [WIN_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TYPE_W-1:0] req_type = REQ_SEND;
   logic [31:0]       req_payload = '0;
   logic [ACK_W-1:0]  req_ack_num = '0;
   logic              req_ack_ok = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic              rsp_tx_valid;
   logic [2:0]        rsp_tx_seq;
   logic [31:0]       rsp_tx_payload;
   logic [TMR_W-1:0]  rsp_timer_cmd;
   logic              rsp_last;

   int   fail_count;
   int   pending;
   int   checked;
   int   items_in = 0;
   int   burst_left = 0;
   int   quiet_cycles = 0;
   logic req_lowered = 1'b1;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   logic [ACK_W-1:0] last_ack = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   go_back_n_sender_window_core u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_payload    (req_payload),
      .req_ack_num    (req_ack_num),
      .req_ack_ok     (req_ack_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_seq     (rsp_tx_seq),
      .rsp_tx_payload (rsp_tx_payload),
      .rsp_timer_cmd  (rsp_timer_cmd),
      .rsp_last       (rsp_last)
   );

   gbn_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_payload    (req_payload),
      .req_ack_num    (req_ack_num),
      .req_ack_ok     (req_ack_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_seq     (rsp_tx_seq),
      .rsp_tx_payload (rsp_tx_payload),
      .rsp_timer_cmd  (rsp_timer_cmd),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   // Offer one item from a falling edge, hold it until taken, then maybe pause
   task automatic offer_item(input logic [TYPE_W-1:0] kind, input logic [31:0] word,
                             input logic [ACK_W-1:0] ack, input logic ok);
      int gap;
      req_valid   <= 1'b1;
      req_lowered  = 1'b0;
      req_type    <= kind;
      req_payload <= word;
      req_ack_num <= ack;
      req_ack_ok  <= ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_in++;
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid  <= 1'b0;
            req_lowered = 1'b1;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Mostly sends and acks, acks often repeated to build up duplicates
   task automatic offer_random();
      int pick;
      logic [31:0] word;
      pick = $urandom_range(0, 99);
      word = $urandom;
      if ($urandom_range(0, 9) == 0) word = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      if (pick < 45) begin
         offer_item(REQ_SEND, word, 3'($urandom), 1'($urandom));
      end else if (pick < 82) begin
         if ($urandom_range(0, 3) != 0) last_ack = 3'($urandom_range(0, 7));
         offer_item(REQ_ACK, word, last_ack, $urandom_range(0, 9) != 0);
      end else if (pick < 96) begin
         offer_item(REQ_TIMEOUT, word, 3'($urandom), 1'($urandom));
      end else begin
         offer_item(REQ_UNKNOWN, word, 3'($urandom), 1'($urandom));
      end
   endtask

   // Drain: nothing offered, nothing expected, block given time to go idle
   task automatic settle(input int tail);
      @(negedge clock);
      if (!req_lowered) begin
         req_valid  <= 1'b0;
         req_lowered = 1'b1;
      end
      while (pending != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   function automatic logic [WIN_W-1:0] plan_window(int p);
      case (p)
         0:       return 3'd7;
         1:       return 3'd1;
         2:       return 3'd0;
         3:       return 3'd3;
         4:       return 3'd5;
         5:       return 3'd2;
         default: return 3'd4;
      endcase
   endfunction

   // Stimulus
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill the reset window of 4, refuse, resend, acks of every kind
      offer_item(REQ_SEND, 32'h0000_0000, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'hFFFF_FFFF, 3'd7, 1'b0);
      offer_item(REQ_SEND, 32'h1234_5678, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'h8000_0001, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'hDEAD_BEEF, 3'd0, 1'b1);   // window full
      offer_item(REQ_TIMEOUT, 32'h0, 3'd0, 1'b0);        // four resends
      offer_item(REQ_ACK, 32'h0, 3'd5, 1'b0);            // corrupt
      offer_item(REQ_ACK, 32'h0, 3'd7, 1'b1);            // duplicate
      offer_item(REQ_ACK, 32'h0, 3'd7, 1'b1);            // fast retransmit
      offer_item(REQ_ACK, 32'h0, 3'd6, 1'b1);            // counter wraps
      offer_item(REQ_ACK, 32'h0, 3'd1, 1'b1);            // advance, timer restarts
      offer_item(REQ_ACK, 32'h0, 3'd3, 1'b1);            // advance, timer stops
      offer_item(REQ_TIMEOUT, 32'h0, 3'd0, 1'b1);        // nothing outstanding
      offer_item(REQ_UNKNOWN, 32'hA5A5_5A5A, 3'd2, 1'b1);
      offer_item(REQ_ACK, 32'h0, 3'd3, 1'b1);
      offer_item(REQ_ACK, 32'h0, 3'd3, 1'b1);            // retransmit with empty window
      offer_item(REQ_SEND, 32'h0F0F_0F0F, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'hF0F0_F0F0, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'h5555_5555, 3'd0, 1'b1);
      offer_item(REQ_SEND, 32'hAAAA_AAAA, 3'd0, 1'b1);   // sequence number 7
      offer_item(REQ_ACK, 32'h0, 3'd7, 1'b1);            // base wraps to 0
      offer_item(REQ_SEND, 32'h7777_7777, 3'd0, 1'b1);

      // random phases, one window setting each
      for (int p = 0; p < 7; p++) begin
         settle(16);
         csr_we    <= 1'b1;
         csr_wdata <= plan_window(p);
         @(negedge clock);
         csr_we    <= 1'b0;
         if (p == 0) hold_req <= 1'b1;
         repeat ((plan_window(p) == 3'd0) ? 30 : 70) offer_random();
      end

      settle(20);
      $display("tb: %0d items taken, %0d results compared, windows 4 7 1 0 3 5 2 4",
               items_in, checked);
      $display("tb: covered refusals, wrapped sequence numbers, fast retransmits, resends");
      if (fail_count == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Receiver: stall pattern steps through four modes; one long hold on request
   initial begin : receiver
      int rx_cycle;
      rx_cycle = 0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            case ((rx_cycle / 97) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
         $display("tb: done, errors");
         $finish;
      end
   end

endmodule

/* sim.f */
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_dp.sv
src/gbn_ctrl.sv
src/go_back_n_sender_window_core.sv
tb/gbn_checker.sv
tb/tb.sv
